>>> sv/msc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants for the median-of-sample-set core.
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam int MAX_SAMPLES_DEF = 64;
   localparam int SAMPLE_W        = 32;
   localparam int COUNT_OUT_W     = 7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic       insert;
      logic       shift;
      sample_type sample;
   } cell_ctrl_type;

endpackage

>>> sv/median_of_sample_set_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_sample_set_core
// Median of a set of Q16.16 samples, kept in a sorted chain of cells.
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser      | tlast
// req     | in  | [31:0] sample                  | -          | last
// rsp     | out | [31:0] median, [38:32] count   | overflowed | -
//
// One sample beat per cycle while a set is loading. After the beat with
// tlast, n samples kept, the chain shifts the lower middle sample down
// to cell zero and ST_FINISH forms the result; req_tready is low until it is formed.
// A waiting result does not block the next set's loading, only its close.
// Synchronous active-high reset clears the count, flag and handshakes.
// ----------------------------------------------------------------------------
module median_of_sample_set_core #(
   parameter int MAX_SAMPLES = msc_pkg::MAX_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] median, [38:32] sample_count
   output logic        rsp_tuser    // [0] overflowed
);
   import msc_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int DW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DRAIN  = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [DW-1:0]       drain_ff, drain_in;
   logic                odd_ff, odd_in;
   logic [CW-1:0]       n_ff, n_in;
   logic                ovf_hold_ff, ovf_hold_in;
   logic                rsp_valid_ff, rsp_valid_in;
   sample_type          median_ff, median_in;
   logic [COUNT_OUT_W-1:0] rcount_ff, rcount_in;
   logic                rovf_ff, rovf_in;

   logic                accept, full;
   logic [CW-1:0]       n_new, half_cnt;
   logic                slot_free;
   logic [CW+COUNT_OUT_W-1:0] n_wide;
   logic signed [SAMPLE_W:0]  pair_sum;
   cell_ctrl_type       ctrl;

   sample_type          cell_val [MAX_SAMPLES];
   logic                cell_gt  [MAX_SAMPLES];
   sample_type          mid_lo, mid_hi;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(MAX_SAMPLES));
   assign n_new      = count_ff + CW'(!full);
   assign half_cnt   = (n_new - CW'(1)) >> 1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = (state_ff == ST_DRAIN);
   assign ctrl.sample = sample_type'(req_tdata);

   genvar gi;
   generate
      for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
         logic       p_gt;
         sample_type p_val, n_val;
         if (gi == 0) begin : g_first
            assign p_gt  = 1'b0;
            assign p_val = cell_val[gi];
         end else begin : g_mid
            assign p_gt  = cell_gt[gi-1];
            assign p_val = cell_val[gi-1];
         end
         if (gi == MAX_SAMPLES - 1) begin : g_end
            assign n_val = cell_val[gi];
         end else begin : g_next
            assign n_val = cell_val[gi+1];
         end
         msc_cell #(
            .INDEX (gi),
            .CNT_W (CW)
         ) u_cell (
            .clock    (clock),
            .ctrl     (ctrl),
            .count    (count_ff),
            .prev_gt  (p_gt),
            .prev_val (p_val),
            .next_val (n_val),
            .gt       (cell_gt[gi]),
            .val      (cell_val[gi])
         );
      end
      if (MAX_SAMPLES > 1) begin : g_pair
         assign mid_hi = cell_val[1];
      end else begin : g_single
         assign mid_hi = cell_val[0];
      end
   endgenerate

   assign mid_lo   = cell_val[0];
   assign pair_sum = {mid_lo[SAMPLE_W-1], mid_lo} + {mid_hi[SAMPLE_W-1], mid_hi};
   assign n_wide   = {{COUNT_OUT_W{1'b0}}, n_ff};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      drain_in     = drain_ff;
      odd_in       = odd_ff;
      n_in         = n_ff;
      ovf_hold_in  = ovf_hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      median_in    = median_ff;
      rcount_in    = rcount_ff;
      rovf_in      = rovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = n_new;
               ovf_in   = ovf_ff || full;
               if (req_tlast) begin
                  n_in        = n_new;
                  odd_in      = n_new[0];
                  ovf_hold_in = ovf_ff || full;
                  drain_in    = half_cnt[DW-1:0];
                  state_in    = (half_cnt == '0) ? ST_FINISH : ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff - DW'(1);
            if (drain_ff == DW'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               median_in    = odd_ff ? mid_lo : sample_type'(pair_sum[SAMPLE_W:1]);
               rcount_in    = n_wide[COUNT_OUT_W-1:0];
               rovf_in      = ovf_hold_ff;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      odd_ff      <= odd_in;
      n_ff        <= n_in;
      ovf_hold_ff <= ovf_hold_in;
      median_ff   <= median_in;
      rcount_ff   <= rcount_in;
      rovf_ff     <= rovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rcount_ff, median_ff};
   assign rsp_tuser  = rovf_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SAMPLES))
      else $error("kept count beyond capacity");

   a_drain_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> drain_ff != '0)
      else $error("drain counter empty while draining");

   a_close_stalls: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> !req_tready)
      else $error("input taken during set close");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rcount_ff != '0 || CW > COUNT_OUT_W)
      else $error("result with empty set");

endmodule

>>> sv/msc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msc_cell
// One cell of the sorted chain: holds one sample, takes part in an
// ordered insert or shifts down towards cell zero while draining.
// ----------------------------------------------------------------------------
module msc_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                  clock,
   input  msc_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]      count,
   input  logic                  prev_gt,
   input  msc_pkg::sample_type   prev_val,
   input  msc_pkg::sample_type   next_val,
   output logic                  gt,
   output msc_pkg::sample_type   val
);
   import msc_pkg::*;

   sample_type val_ff;
   sample_type val_in;
   logic       occupied;

   always_comb begin
      occupied = CNT_W'(INDEX) < count;
      // empty cells rank above any sample
      gt       = !occupied || (val_ff > ctrl.sample);
      val_in   = val_ff;
      if (ctrl.insert) begin
         if (gt) begin
            val_in = prev_gt ? prev_val : ctrl.sample;
         end
      end else if (ctrl.shift) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule
